// ===== src/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and status codes for the cuckoo hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

   // default geometry
   localparam int LOG2_SLOTS_DEF = 10;
   localparam int ROUNDS_DEF     = 5;

   // opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // response status codes
   localparam logic [2:0] STATUS_PUT_DONE = 3'd0;
   localparam logic [2:0] STATUS_GET_HIT  = 3'd1;
   localparam logic [2:0] STATUS_GET_MISS = 3'd2;
   localparam logic [2:0] STATUS_PUT_FULL = 3'd3;
   localparam logic [2:0] STATUS_REFUSED  = 3'd4;

   // request payload
   typedef struct packed {
      logic        opcode;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   // response payload
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [31:0] spill_key;
      logic [31:0] spill_value;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clear_wr;
      logic       load;
      logic       rd_en;
      logic       slot_wr;
      logic       next_probe;
      logic       displace;
      logic       res_load;
      logic [2:0] res_status;
      logic       out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_zero;
      logic op_put;
      logic key_match;
      logic slot_empty;
      logic last_probe;
      logic last_step;
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage

// ===== src/cht_datapath.sv =====
// ----------------------------------------------------------------------------
// cht_datapath
// Slot memory, hash units, carried entry, step counters and response
// registers of the cuckoo hash table.
// ----------------------------------------------------------------------------
module cht_datapath #(
   parameter int LOG2_SLOTS = cht_pkg::LOG2_SLOTS_DEF,
   parameter int ROUNDS     = cht_pkg::ROUNDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cht_pkg::req_type req_payload,
   input  cht_pkg::cmd_type cmd,
   output cht_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_payload
);
   import cht_pkg::*;

   localparam int SLOTS     = 1 << LOG2_SLOTS;
   localparam int STEPS     = ROUNDS * 3;
   localparam int STEP_W    = $clog2(STEPS);
   localparam int SLOT_W    = LOG2_SLOTS;
   localparam logic [1:0] WHICH_LAST = 2'd2;

   // slot memory, key in the upper half
   logic [63:0] mem [SLOTS];
   logic [63:0] rd_ff;

   // carried entry and progress
   logic              op_ff;
   logic [31:0]       ck_ff, ck_in;
   logic [31:0]       cv_ff, cv_in;
   logic [1:0]        which_ff, which_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0] addr_ff;
   logic [SLOT_W-1:0] clr_cnt_ff;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff;
   logic              out_valid_ff, out_valid_in;

   logic [31:0]       rd_key;
   logic [31:0]       rd_value;
   logic [SLOT_W-1:0] k_lo;
   logic [SLOT_W-1:0] hash_addr;

   assign rd_key   = rd_ff[63:32];
   assign rd_value = rd_ff[31:0];

   // three slot hashes of the carried key
   assign k_lo = ck_ff[SLOT_W-1:0];
   always_comb begin
      unique case (which_ff)
         2'd0:    hash_addr = k_lo;
         2'd1:    hash_addr = ck_ff[SLOT_W+3:4];
         2'd2:    hash_addr = SLOT_W'({k_lo, 5'b0} - {5'b0, k_lo});
         default: hash_addr = k_lo;
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_cnt_ff] <= 64'd0;
      end else if (cmd.slot_wr) begin
         mem[addr_ff] <= {ck_ff, cv_ff};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[hash_addr];
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
      end
   end

   // carried entry, probe index and step count
   always_comb begin
      ck_in    = ck_ff;
      cv_in    = cv_ff;
      which_in = which_ff;
      step_in  = step_ff;
      if (cmd.load) begin
         ck_in    = req_payload.key;
         cv_in    = req_payload.value;
         which_in = 2'd0;
         step_in  = '0;
      end else if (cmd.displace) begin
         ck_in    = rd_key;
         cv_in    = rd_value;
         which_in = (which_ff == WHICH_LAST) ? 2'd0 : which_ff + 2'd1;
         step_in  = step_ff + STEP_W'(1);
      end else if (cmd.next_probe) begin
         which_in = which_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ck_ff    <= ck_in;
      cv_ff    <= cv_in;
      which_ff <= which_in;
      step_ff  <= step_in;
      if (cmd.load) begin
         op_ff <= req_payload.opcode;
      end
      if (cmd.rd_en) begin
         addr_ff <= hash_addr;
      end
   end

   // result assembly
   always_comb begin
      res_in = res_ff;
      if (cmd.res_load) begin
         res_in.status      = cmd.res_status;
         res_in.found_value = (cmd.res_status == STATUS_GET_HIT)  ? rd_value : 32'd0;
         res_in.spill_key   = (cmd.res_status == STATUS_PUT_FULL) ? rd_key   : 32'd0;
         res_in.spill_value = (cmd.res_status == STATUS_PUT_FULL) ? rd_value : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // status to controller
   assign sts.req_zero   = (req_payload.key == 32'd0);
   assign sts.op_put     = (op_ff == OP_PUT);
   assign sts.key_match  = (rd_key == ck_ff);
   assign sts.slot_empty = (rd_key == 32'd0);
   assign sts.last_probe = (which_ff == WHICH_LAST);
   assign sts.last_step  = (step_ff == STEP_W'(STEPS - 1));
   assign sts.clear_last = &clr_cnt_ff;
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

endmodule

// ===== src/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for the cuckoo hash table: clearing pass, probes of a get,
// displacement chain of a put and response hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::sts_type sts,
   output cht_pkg::cmd_type cmd,
   output logic             clearing
);
   import cht_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_zero) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_REFUSED;
                  state_in       = ST_RESP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.op_put) begin
               // write carried entry, pick up the old occupant
               cmd.slot_wr = 1'b1;
               if (sts.slot_empty || sts.key_match) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_PUT_DONE;
                  state_in       = ST_RESP;
               end else if (sts.last_step) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_PUT_FULL;
                  state_in       = ST_RESP;
               end else begin
                  cmd.displace = 1'b1;
                  state_in     = ST_READ;
               end
            end else begin
               if (sts.key_match) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_GET_HIT;
                  state_in       = ST_RESP;
               end else if (sts.last_probe) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_GET_MISS;
                  state_in       = ST_RESP;
               end else begin
                  cmd.next_probe = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign clearing  = (state_ff == ST_CLEAR);

endmodule

// ===== src/cuckoo_hash_table.sv =====
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Single-table cuckoo map of 32-bit keys to 32-bit values with three hashes.
// ----------------------------------------------------------------------------
// After reset the block clears all 2^LOG2_SLOTS slots, one per cycle, and
// holds req_stall high until the clearing pass is done. Each request then
// takes one memory probe or displacement at a time through the single slot
// memory port: a registered read in the READ state followed by a compare in
// the CHECK state, where a put also writes its carried entry. A get makes
// 1 to 3 probes; a put writes 1 to 3*ROUNDS slots along its displacement
// chain; a zero key is refused without a probe. A finished response waits in
// an output register, so a new request can be taken while it is stalled.
module cuckoo_hash_table #(
   parameter int LOG2_SLOTS = cht_pkg::LOG2_SLOTS_DEF,
   parameter int ROUNDS     = cht_pkg::ROUNDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_payload
);
   import cht_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    clearing;

   // sequencer
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .clearing  (clearing)
   );

   // memory and data registers
   cht_datapath #(
      .LOG2_SLOTS (LOG2_SLOTS),
      .ROUNDS     (ROUNDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // no request taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request accepted during clearing pass");

   // a taken request blocks the input for the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after request");

   // found value only on a get hit
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_GET_HIT) |-> rsp_payload.found_value == 32'd0)
      else $error("found value set without a hit");

   // spill fields only on put full
   a_spill_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_PUT_FULL)
      |-> (rsp_payload.spill_key == 32'd0 && rsp_payload.spill_value == 32'd0))
      else $error("spill fields set without full");

endmodule

// ===== dv/tb_cuckoo_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_cuckoo_hash_table
// Self-checking bench for the cuckoo hash table. A local copy of the slot
// table predicts every response as requests are accepted. Responses are
// compared field by field in order. Traffic runs a short directed set
// first: empty table, zero key, extreme keys and values, updates,
// displacement chains and a full table. Random gets and puts with random,
// clustered and known keys follow, under three idle mixes and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_table;
   import cht_pkg::*;

   localparam int          SLOT_COUNT  = 1 << LOG2_SLOTS_DEF;
   localparam logic [31:0] SLOT_MASK   = SLOT_COUNT - 1;
   localparam int          MAX_MOVES   = 3 * ROUNDS_DEF;
   localparam int          HASH_SHIFT  = 4;
   localparam logic [31:0] HASH_MULT   = 32'd31;
   localparam logic [11:0] CLUSTER_LOW = 12'h5A7;
   localparam int          KNOWN_DEPTH = 48;
   localparam int          LONG_HOLD   = 400;
   localparam int          DRAIN_WAIT  = 64;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          PRINT_LIMIT = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // local copy of the slot table
   logic [31:0] mirror_key   [SLOT_COUNT];
   logic [31:0] mirror_value [SLOT_COUNT];

   rsp_type     owed_rsp [$];
   logic [31:0] known_keys [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          hold_left = 0;

   cuckoo_hash_table #(
      .LOG2_SLOTS (LOG2_SLOTS_DEF),
      .ROUNDS     (ROUNDS_DEF)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // slot for one of the three hashes of a key
   function automatic int unsigned slot_index(logic [31:0] k, int which);
      logic [31:0] h;
      case (which)
         0: h = k;
         1: h = k >> HASH_SHIFT;
         default: h = k * HASH_MULT;
      endcase
      return h & SLOT_MASK;
   endfunction

   // table access: returns the response and updates the local table
   function automatic rsp_type cuckoo_access(req_type rq);
      rsp_type     r;
      logic [31:0] carry_key;
      logic [31:0] carry_val;
      logic [31:0] old_key;
      logic [31:0] old_val;
      int unsigned s;
      bit          settled;
      r = '0;
      settled = 1'b0;
      if (rq.key == 32'd0) begin
         r.status = STATUS_REFUSED;
      end else if (rq.opcode == OP_GET) begin
         r.status = STATUS_GET_MISS;
         for (int w = 0; w < 3 && !settled; w++) begin
            s = slot_index(rq.key, w);
            if (mirror_key[s] == rq.key) begin
               r.status = STATUS_GET_HIT;
               r.found_value = mirror_value[s];
               settled = 1'b1;
            end
         end
      end else begin
         carry_key = rq.key;
         carry_val = rq.value;
         for (int step = 0; step < MAX_MOVES && !settled; step++) begin
            s = slot_index(carry_key, step % 3);
            old_key = mirror_key[s];
            old_val = mirror_value[s];
            mirror_key[s] = carry_key;
            mirror_value[s] = carry_val;
            if (old_key == 32'd0 || old_key == carry_key) begin
               settled = 1'b1;
            end else begin
               carry_key = old_key;
               carry_val = old_val;
            end
         end
         if (settled) begin
            r.status = STATUS_PUT_DONE;
         end else begin
            r.status = STATUS_PUT_FULL;
            r.spill_key = carry_key;
            r.spill_value = carry_val;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("response %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (owed_rsp.size() == 0) begin
         report_mismatch("with none owed, status", 32'(got.status), 32'd0);
         return;
      end
      want = owed_rsp.pop_front();
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.found_value !== want.found_value)
         report_mismatch("found_value", got.found_value, want.found_value);
      if (got.spill_key !== want.spill_key)
         report_mismatch("spill_key", got.spill_key, want.spill_key);
      if (got.spill_value !== want.spill_value)
         report_mismatch("spill_value", got.spill_value, want.spill_value);
   endtask

   // check accepted responses, predict accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            check_response(rsp_payload);
         if (req_valid && !req_stall)
            owed_rsp.push_back(cuckoo_access(req_payload));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cuckoo_hash_table: mismatch");
         $finish;
      end
   end

   // response side stall: long hold-off first, else random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // offer one request, starting and ending at a falling edge
   task automatic send_request(req_type rq);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(logic op, logic [31:0] k, logic [31:0] v);
      req_type rq;
      rq.opcode = op;
      rq.key = k;
      rq.value = v;
      send_request(rq);
   endtask

   function automatic logic [31:0] draw_key(int known_pct, int cluster_pct);
      logic [31:0] k;
      int          pick;
      pick = $urandom_range(0, 99);
      k = $urandom();
      if (pick < known_pct && known_keys.size() != 0) begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < known_pct + cluster_pct) begin
         // all three hashes land in a handful of slots
         k[13:12] = 2'($urandom_range(0, 3));
         k[11:0] = CLUSTER_LOW;
      end
      if (k == 32'd0)
         k = 32'd1;
      return k;
   endfunction

   task automatic set_idle(int req_pct, int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   // empty table and zero key
   task automatic test_empty_and_refused();
      send_fields(OP_GET, 32'd1, 32'd0);
      send_fields(OP_PUT, 32'd0, 32'hFFFF_FFFF);
      send_fields(OP_GET, 32'd0, 32'hFFFF_FFFF);
   endtask

   // extreme keys and values, then an update in place
   task automatic test_extremes_and_update();
      send_fields(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(OP_GET, 32'hFFFF_FFFF, 32'd0);
      send_fields(OP_PUT, 32'd1, 32'd0);
      send_fields(OP_GET, 32'd1, 32'hFFFF_FFFF);
      send_fields(OP_PUT, 32'd1, 32'hA5A5_A5A5);
      send_fields(OP_GET, 32'd1, 32'd0);
   endtask

   // collisions on the first hash push keys to later slots
   task automatic test_displacement();
      send_fields(OP_PUT, 32'h0000_0401, 32'h1234_5678);
      send_fields(OP_GET, 32'd1, 32'd0);
      send_fields(OP_GET, 32'h0000_0401, 32'd0);
      send_fields(OP_PUT, 32'h0000_0400, 32'h0BAD_F00D);
      send_fields(OP_GET, 32'd1, 32'd0);
      send_fields(OP_GET, 32'h0000_0400, 32'd0);
   endtask

   // five keys sharing all three slots overflow the table
   task automatic test_table_full();
      for (int i = 1; i <= 5; i++)
         send_fields(OP_PUT, (32'(i) << 14) | 32'h123, 32'(i) * 32'h1111_1111);
      for (int i = 1; i <= 5; i++)
         send_fields(OP_GET, (32'(i) << 14) | 32'h123, 32'd0);
   endtask

   // mixed gets and puts, a few zero keys
   task automatic test_random_traffic(int count);
      req_type rq;
      int      pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         rq.value = $urandom();
         if (pick < 3) begin
            rq.opcode = 1'($urandom_range(0, 1));
            rq.key = 32'd0;
         end else if (pick < 50) begin
            rq.opcode = OP_PUT;
            rq.key = draw_key(30, 25);
         end else begin
            rq.opcode = OP_GET;
            rq.key = draw_key(60, 15);
         end
         send_request(rq);
         if (rq.opcode == OP_PUT && rq.key != 32'd0) begin
            known_keys.push_back(rq.key);
            if (known_keys.size() > KNOWN_DEPTH)
               void'(known_keys.pop_front());
         end
      end
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      @(posedge clock);
      hold_left = LONG_HOLD;
      @(negedge clock);
      test_random_traffic(30);
   endtask

   initial begin
      foreach (mirror_key[i]) begin
         mirror_key[i] = 32'd0;
         mirror_value[i] = 32'd0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idle(26, 87);
      test_empty_and_refused();
      test_extremes_and_update();
      test_displacement();
      test_table_full();
      test_random_traffic(300);
      set_idle(87, 26);
      test_random_traffic(300);
      set_idle(0, 0);
      test_random_traffic(270);
      test_backpressure();
      req_valid <= 1'b0;

      // drain
      while (owed_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("cuckoo_hash_table: match");
      else
         $display("cuckoo_hash_table: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cht_pkg.sv
src/cht_datapath.sv
src/cht_ctrl.sv
src/cuckoo_hash_table.sv
dv/tb_cuckoo_hash_table.sv
